[design/mrdd_pkg.sv]
// shared types and constants for the meter readout digit pipeline
package mrdd_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned MagW   = 17;
  localparam int unsigned MilliW = 15;
  localparam int unsigned DigitW = 4;
  localparam int unsigned TensW  = 2;

  // full-scale converter codes
  localparam logic [RawW-1:0] FullScalePos = 16'h7FFF;
  localparam logic [RawW-1:0] FullScaleNeg = 16'h8000;

  // reciprocal constants for the constant divides, exact over each stage's range
  localparam logic [16:0] Recip1000 = 17'd67109;  // /1000 as *67109 >> 26, x < 2^15
  localparam logic [5:0]  Recip100  = 6'd41;      // /100 as *41 >> 12, x < 1000
  localparam logic [7:0]  Recip10   = 8'd205;     // /10 as *205 >> 11, x < 100

  // side-band fields that travel with each beat
  typedef struct packed {
    logic chan;
    logic amps;
    logic neg;
    logic over;
  } tag_t;

endpackage

[design/mrdd_digits.sv]
// pipelined split of a milli-unit reading into five decimal digits
module mrdd_digits (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  mrdd_pkg::tag_t                      in_tag,
  input  logic [mrdd_pkg::MilliW-1:0]         milli,
  output logic                                out_valid,
  output mrdd_pkg::tag_t                      out_tag,
  output logic [mrdd_pkg::TensW-1:0]          tens,
  output logic [mrdd_pkg::DigitW-1:0]         ones,
  output logic [mrdd_pkg::DigitW-1:0]         tenths,
  output logic [mrdd_pkg::DigitW-1:0]         hundredths,
  output logic [mrdd_pkg::DigitW-1:0]         thousandths
);

  // stage c: thousands quotient
  logic                          c_valid;
  mrdd_pkg::tag_t                c_tag;
  logic [mrdd_pkg::MilliW-1:0]   c_milli;
  logic [4:0]                    c_q1k;
  // stage d: whole digits and remainder below 1000
  logic                          d_valid;
  mrdd_pkg::tag_t                d_tag;
  logic [mrdd_pkg::TensW-1:0]    d_tens;
  logic [mrdd_pkg::DigitW-1:0]   d_ones;
  logic [9:0]                    d_r1k;
  // stage e: tenths digit
  logic                          e_valid;
  mrdd_pkg::tag_t                e_tag;
  logic [mrdd_pkg::TensW-1:0]    e_tens;
  logic [mrdd_pkg::DigitW-1:0]   e_ones;
  logic [mrdd_pkg::DigitW-1:0]   e_d100;
  logic [9:0]                    e_r1k;
  // stage f: remainder below 100
  logic                          f_valid;
  mrdd_pkg::tag_t                f_tag;
  logic [mrdd_pkg::TensW-1:0]    f_tens;
  logic [mrdd_pkg::DigitW-1:0]   f_ones;
  logic [mrdd_pkg::DigitW-1:0]   f_d100;
  logic [6:0]                    f_r100;
  // stage g: hundredths digit
  logic                          g_valid;
  mrdd_pkg::tag_t                g_tag;
  logic [mrdd_pkg::TensW-1:0]    g_tens;
  logic [mrdd_pkg::DigitW-1:0]   g_ones;
  logic [mrdd_pkg::DigitW-1:0]   g_d100;
  logic [mrdd_pkg::DigitW-1:0]   g_d10;
  logic [6:0]                    g_r100;

  logic [31:0] prod_1k;
  logic [4:0]  q1k_next;
  logic [14:0] r1k_full;
  logic [mrdd_pkg::TensW-1:0]  tens_next;
  logic [4:0]  ones_full;
  logic [15:0] prod_100;
  logic [9:0]  r100_full;
  logic [14:0] prod_10;
  logic [6:0]  r10_full;

  // quotient is taken from the incoming reading so it lines up with c_milli
  always_comb begin
    prod_1k  = 32'(milli) * 32'(mrdd_pkg::Recip1000);
    q1k_next = prod_1k[30:26];
  end

  always_comb begin
    r1k_full = c_milli - 15'(c_q1k) * 15'd1000;
    if (c_q1k >= 5'd20) begin
      tens_next = 2'd2;
      ones_full = c_q1k - 5'd20;
    end else if (c_q1k >= 5'd10) begin
      tens_next = 2'd1;
      ones_full = c_q1k - 5'd10;
    end else begin
      tens_next = 2'd0;
      ones_full = c_q1k;
    end
  end

  always_comb begin
    prod_100  = 16'(d_r1k) * 16'(mrdd_pkg::Recip100);
    r100_full = e_r1k - 10'(e_d100) * 10'd100;
    prod_10   = 15'(f_r100) * 15'(mrdd_pkg::Recip10);
    r10_full  = g_r100 - 7'(g_d10) * 7'd10;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      g_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      c_valid   <= in_valid;
      d_valid   <= c_valid;
      e_valid   <= d_valid;
      f_valid   <= e_valid;
      g_valid   <= f_valid;
      out_valid <= g_valid;
    end
    c_tag   <= in_tag;
    c_milli <= milli;
    c_q1k   <= q1k_next;

    d_tag  <= c_tag;
    d_tens <= tens_next;
    d_ones <= ones_full[3:0];
    d_r1k  <= r1k_full[9:0];

    e_tag  <= d_tag;
    e_tens <= d_tens;
    e_ones <= d_ones;
    e_d100 <= prod_100[15:12];
    e_r1k  <= d_r1k;

    f_tag  <= e_tag;
    f_tens <= e_tens;
    f_ones <= e_ones;
    f_d100 <= e_d100;
    f_r100 <= r100_full[6:0];

    g_tag  <= f_tag;
    g_tens <= f_tens;
    g_ones <= f_ones;
    g_d100 <= f_d100;
    g_d10  <= prod_10[14:11];
    g_r100 <= f_r100;

    out_tag     <= g_tag;
    tens        <= g_tens;
    ones        <= g_ones;
    tenths      <= g_d100;
    hundredths  <= g_d10;
    thousandths <= r10_full[3:0];
  end

  a_r1k_range: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> (d_r1k < 10'd1000))
    else $error("remainder below thousand out of range");

  a_split_exact: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> (15'(d_tens) * 15'd10000 + 15'(d_ones) * 15'd1000 + 15'(d_r1k)
                 == $past(c_milli)))
    else $error("thousands split does not recombine");

  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ones <= 4'd9 && tenths <= 4'd9 && hundredths <= 4'd9
                   && thousandths <= 4'd9 && tens <= 2'd2))
    else $error("digit above nine");

  a_amps_no_tens: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_tag.amps) |-> (tens == 2'd0))
    else $error("tens digit set in current mode");

endmodule

[design/meter_reading_to_decimal_digits_core.sv]
// panel-meter readout: signed converter sample to sign, range flag and decimal digits
//
// usage: drive channel, current_mode and raw_sample and raise start; the beat is
// taken at any rising edge where start is high and busy is low. busy is held low,
// so a new sample can be taken on every clock.
// the reading is floor(|raw|*5/8) mV in voltage mode or floor(|raw|/32) mA in
// current mode, shown as tens, ones, tenths, hundredths and thousandths of the unit.
// path: an accepted sample passes the input register, the scaling stage, five
// digit-split stages and the result register before done goes high.
// throughput: one beat per cycle; every stage is a fixed register step.
// each result sits on the result ports for exactly that one cycle while done is
// high; the receiver cannot stall, so it must take the beat then.
// reset (rst, synchronous) clears the valid pipeline; beats in flight are dropped
// and no done pulse follows until a new sample is taken.
module meter_reading_to_decimal_digits_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                channel,
  input  logic                                current_mode,
  input  logic signed [mrdd_pkg::RawW-1:0]    raw_sample,
  output logic                                done,
  output logic                                channel_out,
  output logic                                unit_is_amps,
  output logic                                negative,
  output logic                                over_range,
  output logic [mrdd_pkg::TensW-1:0]          whole_tens,
  output logic [mrdd_pkg::DigitW-1:0]         whole_ones,
  output logic [mrdd_pkg::DigitW-1:0]         tenths_digit,
  output logic [mrdd_pkg::DigitW-1:0]         hundredths_digit,
  output logic [mrdd_pkg::DigitW-1:0]         thousandths_digit
);

  logic                          accept;
  // input register
  logic                          a_valid;
  logic                          a_chan;
  logic                          a_amps;
  logic [mrdd_pkg::RawW-1:0]     a_raw;
  // scaled reading
  logic                          b_valid;
  mrdd_pkg::tag_t                b_tag;
  logic [mrdd_pkg::MilliW-1:0]   b_milli;

  logic                          neg_next;
  logic [mrdd_pkg::MagW-1:0]     mag_next;
  logic [18:0]                   volt_x5;
  logic [mrdd_pkg::MilliW-1:0]   milli_next;
  mrdd_pkg::tag_t                tag_next;
  mrdd_pkg::tag_t                out_tag;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    neg_next = a_raw[mrdd_pkg::RawW-1];
    // most negative code takes magnitude 32768 exactly in 17 bits
    mag_next = neg_next ? (17'h10000 - {1'b0, a_raw}) : {1'b0, a_raw};
    volt_x5  = 19'(mag_next) + (19'(mag_next) << 2);
    if (a_amps) begin
      milli_next = 15'(mag_next[16:5]);
    end else begin
      milli_next = volt_x5[17:3];
    end
    tag_next.chan = a_chan;
    tag_next.amps = a_amps;
    tag_next.neg  = neg_next;
    tag_next.over = (a_raw == mrdd_pkg::FullScalePos) || (a_raw == mrdd_pkg::FullScaleNeg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
    a_chan  <= channel;
    a_amps  <= current_mode;
    a_raw   <= raw_sample;
    b_tag   <= tag_next;
    b_milli <= milli_next;
  end

  mrdd_digits u_digits (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (b_valid),
    .in_tag      (b_tag),
    .milli       (b_milli),
    .out_valid   (done),
    .out_tag     (out_tag),
    .tens        (whole_tens),
    .ones        (whole_ones),
    .tenths      (tenths_digit),
    .hundredths  (hundredths_digit),
    .thousandths (thousandths_digit)
  );

  assign channel_out  = out_tag.chan;
  assign unit_is_amps = out_tag.amps;
  assign negative     = out_tag.neg;
  assign over_range   = out_tag.over;

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 8))
    else $error("result beat without a matching sample beat");

  a_amps_range: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_tag.amps) |-> (b_milli <= 15'd1024))
    else $error("current reading above full scale");

endmodule

[tb/tb.sv]
// self-checking testbench for the meter readout digit core
module tb;

  localparam int unsigned RandomBeats = 1600;
  localparam int unsigned CalmTail    = 300;     // last beats are sent back to back
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 200000;

  typedef struct packed {
    logic                          chan;
    logic                          amps;
    logic [mrdd_pkg::RawW-1:0]     raw;
  } meter_sample_t;

  typedef struct packed {
    logic                          chan;
    logic                          amps;
    logic                          neg;
    logic                          over;
    logic [mrdd_pkg::TensW-1:0]    tens;
    logic [mrdd_pkg::DigitW-1:0]   ones;
    logic [mrdd_pkg::DigitW-1:0]   tenths;
    logic [mrdd_pkg::DigitW-1:0]   hundredths;
    logic [mrdd_pkg::DigitW-1:0]   thousandths;
  } readout_t;

  logic                               clk;
  logic                               rst;
  logic                               start;
  logic                               busy;
  logic                               channel;
  logic                               current_mode;
  logic signed [mrdd_pkg::RawW-1:0]   raw_sample;
  logic                               done;
  logic                               channel_out;
  logic                               unit_is_amps;
  logic                               negative;
  logic                               over_range;
  logic [mrdd_pkg::TensW-1:0]         whole_tens;
  logic [mrdd_pkg::DigitW-1:0]        whole_ones;
  logic [mrdd_pkg::DigitW-1:0]        tenths_digit;
  logic [mrdd_pkg::DigitW-1:0]        hundredths_digit;
  logic [mrdd_pkg::DigitW-1:0]        thousandths_digit;

  meter_sample_t pending_samples[$];
  readout_t      awaited_readouts[$];
  meter_sample_t next_sample;
  meter_sample_t taken_sample;
  readout_t      want;
  logic          beat_taken;
  int unsigned   idle_left;
  int unsigned   beats_sent;
  int unsigned   total_beats;
  int unsigned   cycles;
  int unsigned   errors;

  meter_reading_to_decimal_digits_core dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .channel           (channel),
    .current_mode      (current_mode),
    .raw_sample        (raw_sample),
    .done              (done),
    .channel_out       (channel_out),
    .unit_is_amps      (unit_is_amps),
    .negative          (negative),
    .over_range        (over_range),
    .whole_tens        (whole_tens),
    .whole_ones        (whole_ones),
    .tenths_digit      (tenths_digit),
    .hundredths_digit  (hundredths_digit),
    .thousandths_digit (thousandths_digit)
  );

  // magnitude scaled to milli units, then split into decimal digits
  function automatic readout_t scale_to_digits(meter_sample_t s);
    readout_t    r;
    int unsigned mag;
    int unsigned milli;
    r.chan = s.chan;
    r.amps = s.amps;
    r.neg  = s.raw[mrdd_pkg::RawW-1];
    r.over = (s.raw == mrdd_pkg::FullScalePos) || (s.raw == mrdd_pkg::FullScaleNeg);
    mag    = r.neg ? 32'd65536 - {16'd0, s.raw} : {16'd0, s.raw};
    milli  = s.amps ? (mag >> 5) : ((mag * 5) >> 3);
    r.tens        = 2'(milli / 10000);
    r.ones        = 4'((milli / 1000) % 10);
    r.tenths      = 4'((milli / 100) % 10);
    r.hundredths  = 4'((milli / 10) % 10);
    r.thousandths = 4'(milli % 10);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("meter_reading_to_decimal_digits_core verification failed");
      $finish;
    end
  end

  // driver: new beat at the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (idle_left > 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_samples.size() > 0 && beats_sent + CalmTail < total_beats &&
                   $urandom_range(0, 3) == 0) begin
        start     <= 1'b0;
        idle_left <= $urandom_range(0, 5);
      end else if (pending_samples.size() > 0) begin
        next_sample  = pending_samples.pop_front();
        channel      <= next_sample.chan;
        current_mode <= next_sample.amps;
        raw_sample   <= next_sample.raw;
        start        <= 1'b1;
        beats_sent   <= beats_sent + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check each done beat, then log the beat taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (done) begin
        if (awaited_readouts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual %0d%0d.%0d%0d%0d",
                   $time, whole_tens, whole_ones, tenths_digit,
                   hundredths_digit, thousandths_digit);
        end else begin
          want = awaited_readouts.pop_front();
          check_field("channel_out", want.chan, channel_out);
          check_field("unit_is_amps", want.amps, unit_is_amps);
          check_field("negative", want.neg, negative);
          check_field("over_range", want.over, over_range);
          check_field("whole_tens", want.tens, whole_tens);
          check_field("whole_ones", want.ones, whole_ones);
          check_field("tenths_digit", want.tenths, tenths_digit);
          check_field("hundredths_digit", want.hundredths, hundredths_digit);
          check_field("thousandths_digit", want.thousandths, thousandths_digit);
        end
      end
      if (start && !busy) begin
        taken_sample.chan = channel;
        taken_sample.amps = current_mode;
        taken_sample.raw  = raw_sample;
        awaited_readouts.push_back(scale_to_digits(taken_sample));
      end
    end
  end

  initial begin
    meter_sample_t s;
    int unsigned   kind;
    rst          = 1'b1;
    start        = 1'b0;
    channel      = 1'b0;
    current_mode = 1'b0;
    raw_sample   = '0;
    idle_left    = 0;
    beats_sent   = 0;
    cycles       = 0;
    errors       = 0;

    // zero, full-scale codes, smallest steps and digit boundaries in both modes
    pending_samples.push_back('{1'b0, 1'b0, 16'h0000});
    pending_samples.push_back('{1'b1, 1'b1, 16'h0000});
    pending_samples.push_back('{1'b0, 1'b0, 16'h7FFF});
    pending_samples.push_back('{1'b1, 1'b1, 16'h7FFF});
    pending_samples.push_back('{1'b1, 1'b0, 16'h8000});
    pending_samples.push_back('{1'b0, 1'b1, 16'h8000});
    pending_samples.push_back('{1'b0, 1'b0, 16'hFFFF});
    pending_samples.push_back('{1'b1, 1'b1, 16'hFFFF});
    pending_samples.push_back('{1'b0, 1'b0, 16'h0001});
    pending_samples.push_back('{1'b1, 1'b0, 16'h0008});
    pending_samples.push_back('{1'b0, 1'b1, 16'h001F});
    pending_samples.push_back('{1'b1, 1'b1, 16'h0020});
    pending_samples.push_back('{1'b0, 1'b1, 16'hFFE0});
    pending_samples.push_back('{1'b1, 1'b0, 16'd16000});
    pending_samples.push_back('{1'b0, 1'b0, 16'd15999});
    pending_samples.push_back('{1'b1, 1'b0, 16'h7FFE});
    pending_samples.push_back('{1'b0, 1'b0, 16'h8001});
    pending_samples.push_back('{1'b1, 1'b1, 16'h8001});
    pending_samples.push_back('{1'b0, 1'b0, 16'h5555});
    pending_samples.push_back('{1'b1, 1'b1, 16'hAAAA});
    pending_samples.push_back('{1'b1, 1'b0, 16'hC180});

    for (int i = 0; i < RandomBeats; i++) begin
      s.chan = 1'($urandom);
      s.amps = 1'($urandom);
      kind   = $urandom_range(0, 9);
      if (kind < 6) begin
        s.raw = 16'($urandom);
      end else if (kind == 6) begin
        s.raw = 16'($urandom_range(0, 64));
        if ($urandom_range(0, 1) == 1) s.raw = -s.raw;
      end else if (kind == 7) begin
        s.raw = $urandom_range(0, 1) ? 16'h7FFF - 16'($urandom_range(0, 8))
                                     : 16'h8000 + 16'($urandom_range(0, 8));
      end else if (kind == 8) begin
        s.raw = $urandom_range(0, 1) ? mrdd_pkg::FullScalePos : mrdd_pkg::FullScaleNeg;
      end else begin
        // multiples of 8 or 32 land on exact decimal readings, +-1 crosses them
        s.raw = 16'($urandom_range(0, 4095) * 8) + 16'($urandom_range(0, 2)) - 16'd1;
      end
      pending_samples.push_back(s);
    end
    total_beats = pending_samples.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_samples.size() > 0 || start || awaited_readouts.size() > 0)
      @(negedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0) begin
      $display("meter_reading_to_decimal_digits_core verification clean");
    end else begin
      $display("meter_reading_to_decimal_digits_core verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/mrdd_pkg.sv
design/mrdd_digits.sv
design/meter_reading_to_decimal_digits_core.sv
tb/tb.sv
